FILE: rtl/core/twpa_pkg.sv
// Shared widths, operation codes and transfer payload types of the point aggregator.
`default_nettype none
package twpa_pkg;

    localparam int TIME_BITS  = 32;
    localparam int VALUE_BITS = 32;

    typedef logic        [TIME_BITS-1:0]  t_time;
    typedef logic signed [VALUE_BITS-1:0] t_val;

    // Operation codes carried by the input transfer.
    typedef logic [1:0] t_op;
    localparam t_op OP_AGGREGATE = 2'd0;
    localparam t_op OP_BEGIN     = 2'd1;
    localparam t_op OP_LOAD      = 2'd2;
    localparam t_op OP_READ      = 2'd3;

    typedef struct packed {
        t_op   operation;
        t_time point_time;
        t_val  point_value;
        t_val  point_avg;
        t_val  point_min;
        t_val  point_max;
    } t_in;

    typedef struct packed {
        logic  acc_empty;
        t_time acc_time_out;
        t_val  acc_value_out;
        t_val  acc_avg_out;
        t_val  acc_min_out;
        t_val  acc_max_out;
        t_time last_time;
        t_val  last_value;
        t_val  last_avg;
        t_val  last_min;
        t_val  last_max;
    } t_out;

endpackage
`default_nettype wire

FILE: rtl/core/time_weighted_point_aggregator.sv
// Top level of the time-weighted point aggregator: slots, control and output register.
//
// Usage: points arrive on the input channel (i_in_valid / o_in_ready / i_in_data) with an
// operation code: aggregate, begin next point, load point or read only. Every input
// transfer produces exactly one result on the output channel (o_out_valid / i_out_ready /
// o_out_data) that reports the accumulator slot and the last point after the operation.
// An operation that needs no weighted average shows its result in the cycle after the
// input transfer. An aggregate whose point time matches neither slot runs through the
// bit-serial averaging unit: a multiply pass, a divide pass and a finish step, then the
// commit of the result. The divide pass makes one quotient bit per cycle. Only one item
// is in work at a time; an item that needs no weighted average may follow every cycle
// while the receiver takes each result.
// The output is a register: a new input transfer is taken while a result waits, as long
// as that result is taken in the same cycle. When the receiver stalls, the result holds
// and o_in_ready stays low.
// Reset (synchronous, active low) empties both slots and drops o_out_valid.
`default_nettype none
module time_weighted_point_aggregator (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire twpa_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output twpa_pkg::t_out     o_out_data
);
    import twpa_pkg::*;

    typedef struct packed {
        logic  vld;
        t_time t;
        t_val  v;
        t_val  a;
        t_val  mn;
        t_val  mx;
    } t_slot;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_BUSY   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] r_state, n_state;
    t_slot      r_acc, n_acc, r_col, n_col, r_pt;
    t_val       r_avg;
    logic       r_out_valid;
    t_out       r_out_data;

    t_slot      w_pt;
    logic       w_accept, w_out_free, w_need_wavg, w_update, w_start, w_done;
    t_val       w_avg;

    // Lower min and higher max of two slots.
    function automatic t_slot widen(t_slot d, t_slot s);
        t_slot r;
        r = d;
        if (s.mn < d.mn) r.mn = s.mn;
        if (s.mx > d.mx) r.mx = s.mx;
        return r;
    endfunction

    // Merge of a point at the slot's own time.
    function automatic t_slot merge(t_slot d, t_slot p);
        t_slot r;
        r   = widen(d, p);
        r.a = p.a;
        r.v = p.v;
        return r;
    endfunction

    function automatic t_out emit(t_slot a, t_slot c);
        t_out  o;
        t_slot l;
        o.acc_empty     = !a.vld;
        o.acc_time_out  = a.vld ? a.t  : '0;
        o.acc_value_out = a.vld ? a.v  : '0;
        o.acc_avg_out   = a.vld ? a.a  : '0;
        o.acc_min_out   = a.vld ? a.mn : '0;
        o.acc_max_out   = a.vld ? a.mx : '0;
        l = c.vld ? c : a;
        o.last_time  = l.vld ? l.t  : '0;
        o.last_value = l.vld ? l.v  : '0;
        o.last_avg   = l.vld ? l.a  : '0;
        o.last_min   = l.vld ? l.mn : '0;
        o.last_max   = l.vld ? l.mx : '0;
        return o;
    endfunction

    // Incoming point as a filled slot.
    always_comb begin
        w_pt.vld = 1'b1;
        w_pt.t   = i_in_data.point_time;
        w_pt.v   = i_in_data.point_value;
        w_pt.a   = i_in_data.point_avg;
        w_pt.mn  = i_in_data.point_min;
        w_pt.mx  = i_in_data.point_max;
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    // Next slot contents for a single-cycle operation or for the weighted commit.
    always_comb begin
        n_acc       = r_acc;
        n_col       = r_col;
        w_need_wavg = 1'b0;
        if (r_state == ST_COMMIT) begin
            n_acc.a = r_avg;
            n_acc   = widen(n_acc, r_pt);
            n_col   = r_pt;
        end else begin
            unique case (i_in_data.operation)
                OP_AGGREGATE: begin
                    priority if (!r_acc.vld) begin
                        n_acc = w_pt;
                    end else if (r_acc.t == w_pt.t) begin
                        n_acc = merge(r_acc, w_pt);
                    end else if (!r_col.vld) begin
                        n_col = w_pt;
                        n_acc = widen(r_acc, w_pt);
                    end else if (r_col.t == w_pt.t) begin
                        n_col = merge(r_col, w_pt);
                        n_acc = widen(r_acc, n_col);
                    end else begin
                        w_need_wavg = 1'b1;
                    end
                end
                OP_BEGIN: begin
                    n_acc     = r_col;
                    n_col.vld = 1'b0;
                end
                OP_LOAD: begin
                    n_acc     = w_pt;
                    n_col.vld = 1'b0;
                end
                OP_READ: begin
                    n_acc = r_acc;
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
        end
    end

    assign w_start  = w_accept && w_need_wavg;
    assign w_update = (w_accept && !w_need_wavg) || ((r_state == ST_COMMIT) && w_out_free);

    // Control sequence around the averaging unit.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_start) n_state = ST_BUSY;
            ST_BUSY:   if (w_done) n_state = ST_COMMIT;
            ST_COMMIT: if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    twpa_wavg #(
        .TB(TIME_BITS),
        .VB(VALUE_BITS)
    ) u_wavg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_col_avg  (r_col.a),
        .i_acc_avg  (r_acc.a),
        .i_new_time (w_pt.t),
        .i_col_time (r_col.t),
        .i_acc_time (r_acc.t),
        .o_done     (w_done),
        .o_avg      (w_avg)
    );

    // Slots, held point and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_update) begin
                r_acc       <= n_acc;
                r_col       <= n_col;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_update) r_out_data <= emit(n_acc, n_col);
        if (w_accept) r_pt <= w_pt;
        if (w_done) r_avg <= w_avg;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // No input transfer while an average is in work or waiting to commit.
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_in_ready)
        else $error("input taken while busy");

    // The averaging unit only finishes while the control waits for it.
    a_done_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == ST_BUSY))
        else $error("average finished outside busy state");

    // An empty accumulator reports zero fields.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.acc_empty) |->
        (o_out_data.acc_time_out == '0 && o_out_data.acc_min_out == '0 &&
         o_out_data.acc_max_out == '0))
        else $error("empty accumulator reports data");

    // A started average moves the control to the busy state, never straight back to idle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == ST_BUSY))
        else $error("start without busy state");

endmodule
`default_nettype wire

FILE: rtl/core/twpa_wavg.sv
// Bit-serial time-weighted average: shift-add multiply, restoring divide, saturation.
`default_nettype none
module twpa_wavg #(
    parameter int TB = twpa_pkg::TIME_BITS,
    parameter int VB = twpa_pkg::VALUE_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [VB-1:0] i_col_avg,
    input  wire logic [VB-1:0] i_acc_avg,
    input  wire logic [TB-1:0] i_new_time,
    input  wire logic [TB-1:0] i_col_time,
    input  wire logic [TB-1:0] i_acc_time,
    output logic               o_done,
    output logic      [VB-1:0] o_avg
);

    localparam int DW = TB + 1;
    localparam int PW = VB + TB + 2;
    localparam int NB = VB + TB + 1;
    localparam int CW = $clog2(NB + 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    logic [1:0]    r_phase, n_phase;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_m1, n_m1, r_m2, n_m2, r_sum, n_sum;
    logic [DW-1:0] r_d1, n_d1, r_d2, n_d2;
    logic [TB-1:0] r_dd, n_dd, r_rem, n_rem;
    logic          r_nd, n_nd, r_neg, n_neg;
    logic [NB-1:0] r_num, n_num, r_quo, n_quo;

    logic [DW-1:0] w_d1, w_d2, w_dds, w_ddn;
    logic [PW-1:0] w_add1, w_add2, w_sum, w_sumn, w_mag;
    logic          w_mlast, w_dlast, w_ge;
    logic [TB:0]   w_rsh, w_rsub;
    logic          w_over;
    logic [VB-1:0] w_smag;

    // Signed time differences, one bit wider than a timestamp.
    assign w_d1  = {1'b0, i_new_time} - {1'b0, i_col_time};
    assign w_d2  = {1'b0, i_col_time} - {1'b0, i_acc_time};
    assign w_dds = {1'b0, i_new_time} - {1'b0, i_acc_time};
    assign w_ddn = '0 - w_dds;

    // One multiplier bit of each product per cycle; the top bit weighs negative.
    assign w_mlast = (r_cnt == CW'(DW - 1));
    assign w_add1  = r_d1[0] ? (w_mlast ? ('0 - r_m1) : r_m1) : '0;
    assign w_add2  = r_d2[0] ? (w_mlast ? ('0 - r_m2) : r_m2) : '0;
    assign w_sum   = r_sum + w_add1 + w_add2;
    assign w_sumn  = '0 - w_sum;
    assign w_mag   = w_sum[PW-1] ? w_sumn : w_sum;

    // One quotient bit per cycle.
    assign w_dlast = (r_cnt == CW'(NB - 1));
    assign w_rsh   = {r_rem, r_num[NB-1]};
    assign w_ge    = (w_rsh >= {1'b0, r_dd});
    assign w_rsub  = w_rsh - {1'b0, r_dd};

    // Saturate the magnitude to the signed range, then apply the sign.
    always_comb begin
        if (r_neg) begin
            w_over = (|r_quo[NB-1:VB]) || (r_quo[VB-1] && (|r_quo[VB-2:0]));
            w_smag = w_over ? {1'b1, {(VB-1){1'b0}}} : r_quo[VB-1:0];
        end else begin
            w_over = |r_quo[NB-1:VB-1];
            w_smag = w_over ? {1'b0, {(VB-1){1'b1}}} : r_quo[VB-1:0];
        end
    end

    assign o_done = (r_phase == PH_FIN);
    assign o_avg  = r_neg ? ('0 - w_smag) : w_smag;

    // Sequencer for the multiply and divide passes.
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_m1    = r_m1;
        n_m2    = r_m2;
        n_sum   = r_sum;
        n_d1    = r_d1;
        n_d2    = r_d2;
        n_dd    = r_dd;
        n_nd    = r_nd;
        n_rem   = r_rem;
        n_neg   = r_neg;
        n_num   = r_num;
        n_quo   = r_quo;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_phase = PH_MUL;
                    n_cnt   = '0;
                    n_m1    = {{(PW-VB){i_col_avg[VB-1]}}, i_col_avg};
                    n_m2    = {{(PW-VB){i_acc_avg[VB-1]}}, i_acc_avg};
                    n_sum   = '0;
                    n_d1    = w_d1;
                    n_d2    = w_d2;
                    n_nd    = w_dds[DW-1];
                    n_dd    = w_dds[DW-1] ? w_ddn[TB-1:0] : w_dds[TB-1:0];
                end
            end
            PH_MUL: begin
                n_sum = w_sum;
                n_m1  = r_m1 << 1;
                n_m2  = r_m2 << 1;
                n_d1  = r_d1 >> 1;
                n_d2  = r_d2 >> 1;
                n_cnt = r_cnt + 1'b1;
                if (w_mlast) begin
                    n_phase = PH_DIV;
                    n_cnt   = '0;
                    n_num   = w_mag[NB-1:0];
                    n_neg   = w_sum[PW-1] ^ r_nd;
                    n_rem   = '0;
                    n_quo   = '0;
                end
            end
            PH_DIV: begin
                n_rem = w_ge ? w_rsub[TB-1:0] : w_rsh[TB-1:0];
                n_quo = {r_quo[NB-2:0], w_ge};
                n_num = r_num << 1;
                n_cnt = r_cnt + 1'b1;
                if (w_dlast) begin
                    n_phase = PH_FIN;
                end
            end
            PH_FIN: begin
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
        r_m1  <= n_m1;
        r_m2  <= n_m2;
        r_sum <= n_sum;
        r_d1  <= n_d1;
        r_d2  <= n_d2;
        r_dd  <= n_dd;
        r_nd  <= n_nd;
        r_rem <= n_rem;
        r_neg <= n_neg;
        r_num <= n_num;
        r_quo <= n_quo;
    end

endmodule
`default_nettype wire
